[hw/rtl/tcs_pkg.sv]
// tcs_pkg: shared codes, field widths and defaults of the text console
// used by tcs_cursor and text_console_scroll_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tcs_pkg;

  // default screen geometry
  localparam int DEF_NUM_COLS = 40;
  localparam int DEF_NUM_ROWS = 24;

  // port field widths
  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int PROW_W = 5;
  localparam int PCOL_W = 6;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

  // item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // cursor moves
  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_CR,
    CUR_LF,
    CUR_ADV
  } cur_op_t;

endpackage

`default_nettype wire

[hw/rtl/text_console_scroll_unit.sv]
// text_console_scroll_unit: character-cell console top level with screen memory
// depends on tcs_pkg and tcs_cursor
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// An item (in_func, in_char_code, in_read_row, in_read_col) transfers on a
// rising edge with start high and busy low. Every item gives one result on
// the out_ ports, marked by out_valid for exactly one cycle; it must be taken.
// The screen lives in a one-port-write, one-port-read memory of
// NUM_ROWS*NUM_COLS bytes addressed through a rotating row base, so a scroll
// only bumps the base and drops the valid bit of the new bottom row.
// Rows carry valid bits; a row that is not valid reads as spaces.
// Result per item:
//   put line feed, carriage return, or byte into a valid row: result in the
//     next cycle, next item may transfer right away
//   byte into a row not yet valid since reset, clear or scroll: a blank pass
//     over the row writes NUM_COLS cells, then the result follows
//   read: memory output registered, then the result; busy until then
//   clear and unused code: result in the next cycle
// Reset clears the cursor, the row base and all row valid bits at once;
// no clearing pass runs over the memory. The receiver cannot stall.

module text_console_scroll_unit
  import tcs_pkg::*;
#(
  parameter int NUM_COLS = DEF_NUM_COLS,
  parameter int NUM_ROWS = DEF_NUM_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [PROW_W-1:0] in_read_row,
  input  logic [PCOL_W-1:0] in_read_col,
  output logic              out_valid,
  output logic [CHAR_W-1:0] out_cell_char,
  output logic [PCOL_W-1:0] out_cursor_col_out,
  output logic [PROW_W-1:0] out_cursor_row_out,
  output logic              out_did_scroll
);

  localparam int COL_W  = $clog2(NUM_COLS);
  localparam int ROW_W  = $clog2(NUM_ROWS);
  localparam int DEPTH  = NUM_ROWS * NUM_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP
  } state_t;

  state_t              state_r;
  logic [COL_W-1:0]    cursor_col_r;
  logic [ROW_W-1:0]    cursor_row_r;
  logic [ROW_W-1:0]    base_r;
  logic [NUM_ROWS-1:0] row_valid_r;
  logic [COL_W-1:0]    sweep_col_r;
  logic [CHAR_W-1:0]   char_r;
  logic                rd_ok_r;
  logic                rd_row_valid_r;
  logic [CHAR_W-1:0]   rdata_r;

  logic                out_valid_r;
  logic [CHAR_W-1:0]   out_cell_char_r;
  logic [PCOL_W-1:0]   out_cursor_col_r;
  logic [PROW_W-1:0]   out_cursor_row_r;
  logic                out_did_scroll_r;

  logic [CHAR_W-1:0]   mem [DEPTH];

  // cursor step
  cur_op_t          cur_op;
  logic [COL_W-1:0] cur_col_nxt;
  logic [ROW_W-1:0] cur_row_nxt;
  logic [ROW_W-1:0] base_nxt;
  logic             cur_scroll;

  tcs_cursor #(
    .NUM_COLS (NUM_COLS),
    .NUM_ROWS (NUM_ROWS)
  ) u_cursor (
    .op       (cur_op),
    .col      (cursor_col_r),
    .row      (cursor_row_r),
    .base     (base_r),
    .col_nxt  (cur_col_nxt),
    .row_nxt  (cur_row_nxt),
    .base_nxt (base_nxt),
    .scroll   (cur_scroll)
  );

  // physical row of the cursor
  logic [ROW_W:0]   cur_sum;
  logic [ROW_W-1:0] cur_prow;
  assign cur_sum  = {1'b0, base_r} + {1'b0, cursor_row_r};
  assign cur_prow = (cur_sum >= (ROW_W + 1)'(NUM_ROWS)) ?
                    ROW_W'(cur_sum - (ROW_W + 1)'(NUM_ROWS)) : ROW_W'(cur_sum);

  // physical row of a read request
  logic             rd_in_range;
  logic [ROW_W:0]   rd_sum;
  logic [ROW_W-1:0] rd_prow;
  assign rd_in_range = (32'(in_read_row) < NUM_ROWS) && (32'(in_read_col) < NUM_COLS);
  assign rd_sum      = {1'b0, base_r} + {1'b0, ROW_W'(in_read_row)};
  assign rd_prow     = (rd_sum >= (ROW_W + 1)'(NUM_ROWS)) ?
                       ROW_W'(rd_sum - (ROW_W + 1)'(NUM_ROWS)) : ROW_W'(rd_sum);

  // decode of the offered item
  logic  accept;
  func_t in_func_e;
  logic  is_lf;
  logic  is_cr;
  logic  cur_row_ok;
  logic  sweep_last;
  assign accept     = start && (state_r == ST_IDLE);
  assign in_func_e  = func_t'(in_func);
  assign is_lf      = (in_char_code == CHAR_LF);
  assign is_cr      = (in_char_code == CHAR_CR);
  assign cur_row_ok = row_valid_r[cur_prow];
  assign sweep_last = (sweep_col_r == COL_W'(NUM_COLS - 1));

  // cursor move selection
  always_comb begin
    cur_op = CUR_HOLD;
    if (accept && (in_func_e == FUNC_PUT)) begin
      if (is_lf) begin
        cur_op = CUR_LF;
      end else if (is_cr) begin
        cur_op = CUR_CR;
      end else if (cur_row_ok) begin
        cur_op = CUR_ADV;
      end
    end else if ((state_r == ST_SWEEP) && sweep_last) begin
      cur_op = CUR_ADV;
    end
  end

  // memory write port: a byte at the cursor, or the row blank pass
  logic              mem_we;
  logic [COL_W-1:0]  wr_col;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  assign wr_col    = (state_r == ST_SWEEP) ? sweep_col_r : cursor_col_r;
  assign mem_waddr = ADDR_W'(cur_prow) * ADDR_W'(NUM_COLS) + ADDR_W'(wr_col);
  assign mem_raddr = ADDR_W'(rd_prow) * ADDR_W'(NUM_COLS) + ADDR_W'(in_read_col);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = in_char_code;
    if (state_r == ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_wdata = (sweep_col_r == cursor_col_r) ? char_r : CHAR_BLANK;
    end else if (accept && (in_func_e == FUNC_PUT) && !is_lf && !is_cr && cur_row_ok) begin
      mem_we = 1'b1;
    end
  end

  // screen memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // control, cursor and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      base_r       <= '0;
      row_valid_r  <= '0;
      sweep_col_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            case (in_func_e)
              FUNC_PUT: begin
                if (is_lf || is_cr || cur_row_ok) begin
                  cursor_col_r <= cur_col_nxt;
                  cursor_row_r <= cur_row_nxt;
                  base_r       <= base_nxt;
                  if (cur_scroll) begin
                    row_valid_r[base_r] <= 1'b0;
                  end
                  out_valid_r      <= 1'b1;
                  out_cell_char_r  <= '0;
                  out_cursor_col_r <= PCOL_W'(cur_col_nxt);
                  out_cursor_row_r <= PROW_W'(cur_row_nxt);
                  out_did_scroll_r <= cur_scroll;
                end else begin
                  char_r      <= in_char_code;
                  sweep_col_r <= '0;
                  state_r     <= ST_SWEEP;
                end
              end
              FUNC_READ: begin
                rd_ok_r        <= rd_in_range;
                rd_row_valid_r <= row_valid_r[rd_prow];
                state_r        <= ST_READ;
              end
              FUNC_CLEAR: begin
                cursor_col_r     <= '0;
                cursor_row_r     <= '0;
                base_r           <= '0;
                row_valid_r      <= '0;
                out_valid_r      <= 1'b1;
                out_cell_char_r  <= '0;
                out_cursor_col_r <= '0;
                out_cursor_row_r <= '0;
                out_did_scroll_r <= 1'b0;
              end
              default: begin
                out_valid_r      <= 1'b1;
                out_cell_char_r  <= '0;
                out_cursor_col_r <= PCOL_W'(cursor_col_r);
                out_cursor_row_r <= PROW_W'(cursor_row_r);
                out_did_scroll_r <= 1'b0;
              end
            endcase
          end
        end
        ST_READ: begin
          out_valid_r      <= 1'b1;
          out_cell_char_r  <= !rd_ok_r ? '0 : (rd_row_valid_r ? rdata_r : CHAR_BLANK);
          out_cursor_col_r <= PCOL_W'(cursor_col_r);
          out_cursor_row_r <= PROW_W'(cursor_row_r);
          out_did_scroll_r <= 1'b0;
          state_r          <= ST_IDLE;
        end
        ST_SWEEP: begin
          sweep_col_r <= sweep_col_r + COL_W'(1);
          if (sweep_last) begin
            row_valid_r[cur_prow] <= 1'b1;
            cursor_col_r          <= cur_col_nxt;
            cursor_row_r          <= cur_row_nxt;
            base_r                <= base_nxt;
            if (cur_scroll) begin
              row_valid_r[base_r] <= 1'b0;
            end
            out_valid_r      <= 1'b1;
            out_cell_char_r  <= '0;
            out_cursor_col_r <= PCOL_W'(cur_col_nxt);
            out_cursor_row_r <= PROW_W'(cur_row_nxt);
            out_did_scroll_r <= cur_scroll;
            state_r          <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_cell_char      = out_cell_char_r;
  assign out_cursor_col_out = out_cursor_col_r;
  assign out_cursor_row_out = out_cursor_row_r;
  assign out_did_scroll     = out_did_scroll_r;

  // from ST_READ, a read always delivers its result in the following cycle
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> out_valid_r)
    else $error("read did not deliver a result");

  // the cursor and the row base stay on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cursor_col_r) < NUM_COLS) && (32'(cursor_row_r) < NUM_ROWS) &&
    (32'(base_r) < NUM_ROWS))
    else $error("cursor or row base off the screen");

  // the blank pass only runs over a row that is not yet valid
  a_sweep_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> !row_valid_r[cur_prow])
    else $error("blank pass over a valid row");

  // no result while the blank pass is still running
  a_sweep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SWEEP) && !sweep_last) |=> !out_valid_r)
    else $error("result during blank pass");

endmodule

`default_nettype wire

[hw/rtl/tcs_cursor.sv]
// tcs_cursor: next cursor position, scroll flag and row base of the console
// depends on tcs_pkg (cursor move codes)
`timescale 1ns / 1ps
`default_nettype none

module tcs_cursor
  import tcs_pkg::*;
#(
  parameter int NUM_COLS = DEF_NUM_COLS,
  parameter int NUM_ROWS = DEF_NUM_ROWS,
  localparam int COL_W = $clog2(NUM_COLS),
  localparam int ROW_W = $clog2(NUM_ROWS)
) (
  input  cur_op_t          op,
  input  logic [COL_W-1:0] col,
  input  logic [ROW_W-1:0] row,
  input  logic [ROW_W-1:0] base,
  output logic [COL_W-1:0] col_nxt,
  output logic [ROW_W-1:0] row_nxt,
  output logic [ROW_W-1:0] base_nxt,
  output logic             scroll
);

  logic last_col;
  logic last_row;
  logic newline;

  assign last_col = (col == COL_W'(NUM_COLS - 1));
  assign last_row = (row == ROW_W'(NUM_ROWS - 1));
  assign newline  = (op == CUR_LF) || ((op == CUR_ADV) && last_col);
  assign scroll   = newline && last_row;

  // column step
  always_comb begin
    case (op)
      CUR_CR,
      CUR_LF:  col_nxt = '0;
      CUR_ADV: col_nxt = last_col ? '0 : col + COL_W'(1);
      default: col_nxt = col;
    endcase
  end

  // row step, bottom row stays put and the base rotates instead
  assign row_nxt  = (newline && !last_row) ? row + ROW_W'(1) : row;
  assign base_nxt = !scroll ? base :
                    (base == ROW_W'(NUM_ROWS - 1)) ? '0 : base + ROW_W'(1);

endmodule

`default_nettype wire
